/* sv/psu_pkg.sv */
// Package for the PNG scanline unfilter: field widths, filter and register codes,
// and the Paeth predictor. No dependencies; compiled first.
package psu_pkg;

    // Fixed field widths
    localparam int BYTE_W         = 8;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int ROW_W          = 16;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int LANE_W         = $clog2(BYTES_PER_PIXEL);
    localparam int MAX_WIDTH_DEF  = 1024;

    // Row filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    // Paeth predictor: nearest of left, up, upper-left to left + up - upper-left
    function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [BYTE_W-1:0] c);
        logic signed [BYTE_W+2:0] da;
        logic signed [BYTE_W+2:0] db;
        logic signed [BYTE_W+2:0] dc;
        logic [BYTE_W+2:0]        pa;
        logic [BYTE_W+2:0]        pb;
        logic [BYTE_W+2:0]        pc;
        da = signed'({3'b000, b}) - signed'({3'b000, c});
        db = signed'({3'b000, a}) - signed'({3'b000, c});
        dc = da + db;
        pa = (da < 0) ? unsigned'(-da) : unsigned'(da);
        pb = (db < 0) ? unsigned'(-db) : unsigned'(db);
        pc = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

endpackage

/* sv/psu_if.sv */
// Stream interfaces for the scanline unfilter: input bytes, result bytes and
// the configuration write channel. Depends on psu_pkg.
interface psu_byte_if
    import psu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface psu_pix_if
    import psu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_of_image;
    logic              error_flag;

    modport source (output valid, output pixel_byte, output last_of_image,
                    output error_flag, input ready);
    modport sink   (input valid, input pixel_byte, input last_of_image,
                    input error_flag, output ready);
endinterface

interface psu_cfg_if
    import psu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/png_scanline_unfilter_rgba8.sv */
// Throughput: one byte per cycle unless the output stalls; the line store is read
// on the accepting edge and written back one stage later, so a byte follows in the
// next cycle without stalls. A sample byte passes stage 1, then the output register,
// before its result beat. A bad filter-type byte gives an error beat; other
// filter-type bytes and bytes dropped while halted give no beat.
// Reset: counters clear, the halt flag clears, width and height read 1; the line store
// is not cleared (row 0 ignores it), so there is no clearing pass.
module png_scanline_unfilter_rgba8
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    psu_byte_if.sink      byte_in,
    psu_pix_if.source     pix_out,
    psu_cfg_if.sink       cfg
);

    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W    = COL_W + LANE_W;
    localparam int MEM_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;

    // Configuration and stream control
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg,  col_next;
    logic [LANE_W-1:0]       lane_reg, lane_next;
    logic [ROW_W-1:0]        row_reg,  row_next;
    filt_t                   filt_reg, filt_next;
    logic                    await_reg, await_next;
    logic                    halted_reg, halted_next;

    // Stage 1 (line store read in flight)
    logic                    s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0]       s1_byte_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic [LANE_W-1:0]       s1_lane_reg;
    filt_t                   s1_filt_reg;
    logic                    s1_col0_reg;
    logic                    s1_rownz_reg;
    logic                    s1_last_reg;
    logic                    s1_err_reg;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       out_pix_reg;
    logic                    out_last_reg;
    logic                    out_err_reg;

    // Line store and neighbour bytes
    logic [BYTE_W-1:0]       row_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]       mem_q_reg;
    logic [BYTE_W-1:0]       left_reg  [BYTES_PER_PIXEL];
    logic [BYTE_W-1:0]       upleft_reg[BYTES_PER_PIXEL];

    logic                    in_acc, cfg_acc, s1_adv;
    logic                    data_acc, bad_filt, load_s1;
    logic [EW_W-1:0]         eff_w;
    logic [CFG_HEIGHT_W-1:0] eff_h;
    logic                    col_last, row_last, byte_last;
    logic [ADDR_W-1:0]       rd_addr;
    logic [BYTE_W-1:0]       nb_a, nb_b, nb_c, pred, recon;
    logic [BYTE_W:0]         avg_sum;

    // Handshakes
    assign cfg.ready     = 1'b1;
    assign cfg_acc       = cfg.valid;
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign byte_in.ready = !s1_valid_reg || s1_adv;
    assign in_acc        = byte_in.valid && byte_in.ready;

    assign bad_filt = byte_in.data_byte > BYTE_W'(FILT_PAETH);
    assign data_acc = in_acc && !halted_reg && !await_reg;
    assign load_s1  = data_acc || (in_acc && !halted_reg && await_reg && bad_filt);

    // Effective geometry: width 0 acts as 1, above the store as the store size
    always_comb
    begin
        if (width_reg == '0)
            eff_w = EW_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = EW_W'(MAX_WIDTH);
        else
            eff_w = EW_W'(width_reg);
        eff_h = (height_reg == '0) ? CFG_HEIGHT_W'(1) : height_reg;
    end

    assign col_last  = ((EW_W+1)'(col_reg) + (EW_W+1)'(1)) >= {1'b0, eff_w};
    assign row_last  = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h};
    assign byte_last = (lane_reg == LANE_W'(BYTES_PER_PIXEL - 1)) && col_last;
    assign rd_addr   = {col_reg, lane_reg};

    // Stream position counters
    always_comb
    begin
        col_next    = col_reg;
        lane_next   = lane_reg;
        row_next    = row_reg;
        filt_next   = filt_reg;
        await_next  = await_reg;
        halted_next = halted_reg;
        if (cfg_acc)
        begin
            col_next    = '0;
            lane_next   = '0;
            row_next    = '0;
            filt_next   = FILT_NONE;
            await_next  = 1'b1;
            halted_next = 1'b0;
        end
        else if (in_acc && !halted_reg && await_reg)
        begin
            if (bad_filt)
                halted_next = 1'b1;
            else
            begin
                filt_next  = filt_t'(byte_in.data_byte[2:0]);
                await_next = 1'b0;
                col_next   = '0;
                lane_next  = '0;
            end
        end
        else if (data_acc)
        begin
            lane_next = lane_reg + LANE_W'(1);
            if (lane_reg == LANE_W'(BYTES_PER_PIXEL - 1))
            begin
                if (col_last)
                begin
                    col_next   = '0;
                    await_next = 1'b1;
                    row_next   = row_last ? '0 : row_reg + ROW_W'(1);
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_W'(1);
            height_reg <= CFG_HEIGHT_W'(1);
            col_reg    <= '0;
            lane_reg   <= '0;
            row_reg    <= '0;
            filt_reg   <= FILT_NONE;
            await_reg  <= 1'b1;
            halted_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg.data[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg.data[CFG_HEIGHT_W-1:0];
                    default:          ;
                endcase
            end
            col_reg    <= col_next;
            lane_reg   <= lane_next;
            row_reg    <= row_next;
            filt_reg   <= filt_next;
            await_reg  <= await_next;
            halted_reg <= halted_next;
        end
    end

    // Stage 1 control
    assign s1_valid_next = load_s1 || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_byte_reg  <= byte_in.data_byte;
            s1_addr_reg  <= rd_addr;
            s1_lane_reg  <= lane_reg;
            s1_filt_reg  <= filt_reg;
            s1_col0_reg  <= (col_reg == '0);
            s1_rownz_reg <= (row_reg != '0);
            s1_last_reg  <= byte_last && row_last;
            s1_err_reg   <= !data_acc;
        end
    end

    // Line store read (on accept) and write-back (as the byte leaves stage 1)
    always_ff @(posedge clk)
    begin
        if (data_acc)
            mem_q_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && !s1_err_reg)
            row_mem[s1_addr_reg] <= recon;
    end

    // Neighbours: zero on the first column and on row 0
    assign nb_a    = s1_col0_reg  ? '0 : left_reg[s1_lane_reg];
    assign nb_c    = s1_col0_reg  ? '0 : upleft_reg[s1_lane_reg];
    assign nb_b    = s1_rownz_reg ? mem_q_reg : '0;
    assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

    // Predictor and reconstruction
    always_comb
    begin
        case (s1_filt_reg)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
            default:    pred = '0;
        endcase
    end

    assign recon = s1_byte_reg + pred;

    always_ff @(posedge clk)
    begin
        if (s1_adv && !s1_err_reg)
        begin
            left_reg[s1_lane_reg]   <= recon;
            upleft_reg[s1_lane_reg] <= nb_b;
        end
    end

    // Output register
    assign out_valid_next = s1_adv || (out_valid_reg && !pix_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pix_reg  <= s1_err_reg ? '0 : recon;
            out_last_reg <= !s1_err_reg && s1_last_reg;
            out_err_reg  <= s1_err_reg;
        end
    end

    assign pix_out.valid         = out_valid_reg;
    assign pix_out.pixel_byte    = out_pix_reg;
    assign pix_out.last_of_image = out_last_reg;
    assign pix_out.error_flag    = out_err_reg;

    // Checks
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && !cfg_acc |=> halted_reg)
        else $error("halt cleared without a configuration write");

    a_bad_filter_halts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !halted_reg && await_reg && bad_filt && !cfg_acc |=> halted_reg)
        else $error("bad filter type did not halt the stream");

    a_lane_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> lane_reg == '0)
        else $error("row ended part way through a pixel");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("stalled stage 1 byte lost or changed");

    a_err_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_pix_reg == '0 && !out_last_reg)
        else $error("error beat carries pixel data");

endmodule
